[rtl/core/kte_pkg.sv]
// types, codes and edit helpers shared by the keypad time setting editor
// no dependencies; imported by kte_front, kte_back and the top level
package kte_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int QUEUE_DEPTH = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_UP_MAX    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_MIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_MAX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_MIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_MAX = 3'd6;

   // operation codes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;

   // key codes, also the key latch values
   localparam logic [2:0] KEY_NONE  = 3'd0;
   localparam logic [2:0] KEY_UP    = 3'd1;
   localparam logic [2:0] KEY_DOWN  = 3'd2;
   localparam logic [2:0] KEY_LEFT  = 3'd3;
   localparam logic [2:0] KEY_RIGHT = 3'd4;

   // cursor positions
   localparam logic [3:0] POS_PM       = 4'd0;
   localparam logic [3:0] POS_HOUR     = 4'd4;
   localparam logic [3:0] POS_MIN_TENS = 4'd6;
   localparam logic [3:0] POS_MIN_ONES = 4'd7;
   localparam logic [3:0] POS_SEC_TENS = 4'd9;
   localparam logic [3:0] POS_SEC_ONES = 4'd10;
   localparam logic [3:0] POS_ALARM    = 4'd12;

   localparam logic TGT_ALARM = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] ladder_sample;
      logic        target;
      logic        load_pm;
      logic [3:0]  load_hour;
      logic [5:0]  load_minute;
      logic [5:0]  load_second;
   } req_type;

   typedef struct packed {
      logic [2:0] key_event;
      logic [3:0] cursor;
      logic       pm;
      logic [3:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       alarm_off;
      logic       commit;
      logic       commit_target;
   } rsp_type;

   typedef struct packed {
      logic [11:0] up_max;
      logic [11:0] down_min;
      logic [11:0] down_max;
      logic [11:0] left_min;
      logic [11:0] left_max;
      logic [11:0] right_min;
      logic [11:0] right_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      up_max:    12'd15,
      down_min:  12'd830,
      down_max:  12'd870,
      left_min:  12'd1910,
      left_max:  12'd1960,
      right_min: 12'd2920,
      right_max: 12'd3010
   };

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
      logic rel;
   } hits_type;

   // decoded transaction handed from front to back
   typedef struct packed {
      logic [1:0] operation;
      logic       target;
      hits_type   hits;
      logic       load_pm;
      logic [3:0] load_hour;
      logic [5:0] load_minute;
      logic [5:0] load_second;
   } dec_type;

   typedef struct packed {
      logic    valid;
      dec_type data;
   } dec_chan_type;

   typedef struct packed {
      logic       pm;
      logic [3:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       alarm_off;
   } edit_type;

   localparam edit_type EDIT_RESET = '{
      pm: 1'b0, hour: 4'd0, minute: 6'd0, second: 6'd0, alarm_off: 1'b1
   };

   // true when the ones digit of v equals d
   function automatic logic digit_is(logic [5:0] v, logic [3:0] d);
      logic r;
      r = 1'b0;
      for (int k = 0; k < 7; k++) begin
         if ({1'b0, v} == 7'(32'(d) + 10 * k)) begin
            r = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [5:0] tens_step(logic [5:0] v, logic up);
      logic [5:0] r;
      if (up) begin
         r = (v >= 6'd50) ? v - 6'd50 : v + 6'd10;
      end else begin
         r = (v < 6'd10) ? v + 6'd50 : v - 6'd10;
      end
      return r;
   endfunction

   function automatic logic [5:0] ones_step(logic [5:0] v, logic up);
      logic [5:0] r;
      if (up) begin
         r = digit_is(v, 4'd9) ? v - 6'd9 : v + 6'd1;
      end else begin
         r = digit_is(v, 4'd0) ? v + 6'd9 : v - 6'd1;
      end
      return r;
   endfunction

   function automatic edit_type edit_apply(edit_type e, logic [3:0] pos, logic up,
                                           logic tgt);
      edit_type r;
      r = e;
      case (pos)
         POS_PM: r.pm = ~e.pm;
         POS_HOUR: begin
            if (up) begin
               r.hour = (e.hour >= 4'd12) ? 4'd0 : e.hour + 4'd1;
            end else begin
               r.hour = (e.hour == 4'd0) ? 4'd12 : e.hour - 4'd1;
            end
         end
         POS_MIN_TENS: r.minute = tens_step(e.minute, up);
         POS_MIN_ONES: r.minute = ones_step(e.minute, up);
         POS_SEC_TENS: r.second = tens_step(e.second, up);
         POS_SEC_ONES: r.second = ones_step(e.second, up);
         POS_ALARM: begin
            if (tgt == TGT_ALARM) begin
               r.alarm_off = ~e.alarm_off;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] move_left(logic [3:0] p);
      logic [3:0] r;
      if (p == POS_PM) begin
         r = POS_ALARM;
      end else begin
         r = (p == POS_HOUR) ? p - 4'd3 : p;
         if (r == POS_MIN_TENS || r == POS_SEC_TENS || r == POS_ALARM) begin
            r = r - 4'd1;
         end
         r = r - 4'd1;
      end
      return r;
   endfunction

   function automatic logic [3:0] move_right(logic [3:0] p);
      logic [3:0] r;
      if (p >= POS_ALARM) begin
         r = POS_PM;
      end else begin
         r = (p == POS_PM) ? p + 4'd3 : p;
         if (r == POS_HOUR || r == POS_MIN_ONES || r == POS_SEC_ONES) begin
            r = r + 4'd1;
         end
         r = r + 4'd1;
      end
      return r;
   endfunction

endpackage

[rtl/core/kte_front.sv]
// front end: configuration registers, key window decode and decoded queue
// depends on kte_pkg
module kte_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  kte_pkg::req_type                 req_data,
   input  logic                             csr_wen,
   input  logic [kte_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kte_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output kte_pkg::dec_chan_type            dec_out,
   input  logic                             dec_pop
);
   import kte_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   dec_type    q_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push_ok;
   dec_type    dec_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_UP_MAX:    cfg_in.up_max = csr_wdata;
            CSR_DOWN_MIN:  cfg_in.down_min = csr_wdata;
            CSR_DOWN_MAX:  cfg_in.down_max = csr_wdata;
            CSR_LEFT_MIN:  cfg_in.left_min = csr_wdata;
            CSR_LEFT_MAX:  cfg_in.left_max = csr_wdata;
            CSR_RIGHT_MIN: cfg_in.right_min = csr_wdata;
            CSR_RIGHT_MAX: cfg_in.right_max = csr_wdata;
            default: ;
         endcase
      end
   end

   // window compares; the latch-dependent part is resolved in the back end
   always_comb begin
      dec_in.operation = req_data.operation;
      dec_in.target = req_data.target;
      dec_in.hits.up = req_data.ladder_sample <= cfg_ff.up_max;
      dec_in.hits.down = (req_data.ladder_sample >= cfg_ff.down_min) &&
                         (req_data.ladder_sample <= cfg_ff.down_max);
      dec_in.hits.left = (req_data.ladder_sample >= cfg_ff.left_min) &&
                         (req_data.ladder_sample <= cfg_ff.left_max);
      dec_in.hits.right = (req_data.ladder_sample >= cfg_ff.right_min) &&
                          (req_data.ladder_sample <= cfg_ff.right_max);
      dec_in.hits.rel = req_data.ladder_sample > cfg_ff.right_max;
      dec_in.load_pm = req_data.load_pm;
      dec_in.load_hour = req_data.load_hour;
      dec_in.load_minute = req_data.load_minute;
      dec_in.load_second = req_data.load_second;
   end

   assign req_full = count_ff == 2'(QUEUE_DEPTH);
   assign push_ok = req_push && !req_full;
   assign count_in = count_ff + {1'b0, push_ok} - {1'b0, dec_pop};

   assign dec_out.valid = count_ff != 2'd0;
   assign dec_out.data = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
         count_ff <= count_in;
         if (push_ok) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (dec_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= dec_in;
      end
   end

endmodule

[rtl/core/kte_back.sv]
// back end: key latch, cursor and edit state, result queue
// depends on kte_pkg
module kte_back (
   input  logic                  clock,
   input  logic                  reset,
   input  kte_pkg::dec_chan_type dec_in,
   output logic                  dec_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output kte_pkg::rsp_type      rsp_data
);
   import kte_pkg::*;

   logic [2:0] key_latch_ff;
   logic [2:0] key_latch_in;
   logic [3:0] cursor_ff;
   logic [3:0] cursor_in;
   edit_type   edit_ff;
   edit_type   edit_in;
   rsp_type    res_in;
   rsp_type    q_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       res_full;
   logic       out_pop;
   dec_type    d;

   assign d = dec_in.data;
   assign res_full = count_ff == 2'(QUEUE_DEPTH);
   assign dec_pop = dec_in.valid && !res_full;

   always_comb begin
      logic [2:0] key;
      logic       commit;
      key_latch_in = key_latch_ff;
      cursor_in = cursor_ff;
      edit_in = edit_ff;
      key = KEY_NONE;
      commit = 1'b0;
      case (d.operation)
         OP_SAMPLE: begin
            // tests run in order and each sees the latch left by the one before
            if (d.hits.up && key_latch_in != KEY_UP) begin
               key_latch_in = KEY_UP;
               key = KEY_UP;
               edit_in = edit_apply(edit_in, cursor_ff, 1'b1, d.target);
            end
            if (d.hits.down && key_latch_in != KEY_DOWN) begin
               key_latch_in = KEY_DOWN;
               key = KEY_DOWN;
               edit_in = edit_apply(edit_in, cursor_ff, 1'b0, d.target);
            end
            if (d.hits.left && key_latch_in != KEY_LEFT) begin
               key_latch_in = KEY_LEFT;
               key = KEY_LEFT;
               cursor_in = move_left(cursor_in);
            end
            if (d.hits.right && key_latch_in != KEY_RIGHT) begin
               key_latch_in = KEY_RIGHT;
               key = KEY_RIGHT;
               cursor_in = move_right(cursor_in);
            end
            if (d.hits.rel) begin
               key_latch_in = KEY_NONE;
            end
         end
         OP_LOAD: begin
            edit_in.pm = d.load_pm;
            edit_in.hour = d.load_hour;
            edit_in.minute = d.load_minute;
            edit_in.second = d.load_second;
            cursor_in = POS_PM;
         end
         OP_COMMIT: commit = 1'b1;
         default: ;
      endcase
      res_in.key_event = key;
      res_in.cursor = cursor_in;
      res_in.pm = edit_in.pm;
      res_in.hour = edit_in.hour;
      res_in.minute = edit_in.minute;
      res_in.second = edit_in.second;
      res_in.alarm_off = edit_in.alarm_off;
      res_in.commit = commit;
      res_in.commit_target = commit & d.target;
   end

   assign rsp_empty = count_ff == 2'd0;
   assign out_pop = rsp_pop && !rsp_empty;
   assign rsp_data = q_ff[rd_ptr_ff];
   assign count_in = count_ff + {1'b0, dec_pop} - {1'b0, out_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         key_latch_ff <= KEY_NONE;
         cursor_ff <= POS_PM;
         edit_ff <= EDIT_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (dec_pop) begin
            key_latch_ff <= key_latch_in;
            cursor_ff <= cursor_in;
            edit_ff <= edit_in;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (out_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dec_pop) begin
         q_ff[wr_ptr_ff] <= res_in;
      end
   end

endmodule

[rtl/core/keypad_time_setting_editor.sv]
// keypad time setting editor: watch-style time and alarm editing from a
// resistor-ladder keypad. Input side is a queue: a transaction is taken when
// req_push is high and req_full low; operation selects an ADC sample, a load
// of the edit values or a long-press commit. Result side is a queue too: the
// oldest result sits on rsp_data while rsp_empty is low and leaves on rsp_pop.
// Every transaction gives exactly one result, in order.
// From push to rsp_empty low a transaction is registered first in the front
// end (window decode into a two-entry queue) and then in the back end (latch,
// cursor and field update into a two-entry result queue).
// Throughput is one transaction per cycle while the receiver keeps popping,
// set by the state update in the back end.
// When the receiver stops popping, the result queue fills, the back end
// stops draining the decode queue, and req_full rises after at most four
// queued transactions; nothing is lost.
// Configuration is written through csr_wen/csr_index/csr_wdata with no wait;
// write only while the block is idle. Reset (synchronous, active high)
// restores the default key windows, empties both queues, clears the key
// latch, cursor and edit values and sets the alarm off.
module keypad_time_setting_editor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  kte_pkg::req_type                 req_data,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output kte_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wen,
   input  logic [kte_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kte_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kte_pkg::*;

   dec_chan_type dec_chan;
   logic         dec_pop;

   kte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dec_out   (dec_chan),
      .dec_pop   (dec_pop)
   );

   kte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .dec_in    (dec_chan),
      .dec_pop   (dec_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/kte_edit_checker.sv]
`timescale 1ns / 100ps
// result checker for the keypad time setting editor: predicts every result
// and compares it with what comes out. depends on kte_pkg only
module kte_edit_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  kte_pkg::req_type               req_data,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  kte_pkg::rsp_type               rsp_data,
   input  logic                           csr_wen,
   input  logic [kte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kte_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import kte_pkg::*;

   localparam int PRINT_CAP = 60;

   cfg_type    windows;
   logic [2:0] held_key;
   logic [3:0] cursor_pos;
   logic       edit_pm;
   logic [3:0] edit_hour;
   logic [5:0] edit_minute;
   logic [5:0] edit_second;
   logic       alarm_off;

   rsp_type expected_edits[$];
   rsp_type oldest;
   int      mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic logic [5:0] tens_digit_step(logic [5:0] v, logic up);
      int n;
      n = int'(v);
      if (up) begin
         n = (n >= 50) ? n - 50 : n + 10;
      end else begin
         n = (n < 10) ? n + 50 : n - 10;
      end
      return 6'(n);
   endfunction

   // out-of-range values wrap modulo 64
   function automatic logic [5:0] ones_digit_step(logic [5:0] v, logic up);
      int n;
      n = int'(v);
      if (up) begin
         n = (n % 10 == 9) ? n - 9 : n + 1;
      end else begin
         n = (n % 10 == 0) ? n + 9 : n - 1;
      end
      return 6'(n);
   endfunction

   function automatic logic [3:0] cursor_left(logic [3:0] p);
      case (p)
         POS_PM:       return POS_ALARM;
         POS_HOUR:     return POS_PM;
         POS_MIN_TENS: return POS_HOUR;
         POS_SEC_TENS: return POS_MIN_ONES;
         POS_ALARM:    return POS_SEC_ONES;
         default:      return p - 4'd1;
      endcase
   endfunction

   function automatic logic [3:0] cursor_right(logic [3:0] p);
      if (p >= POS_ALARM) begin
         return POS_PM;
      end
      case (p)
         POS_PM:       return POS_HOUR;
         POS_HOUR:     return POS_MIN_TENS;
         POS_MIN_ONES: return POS_SEC_TENS;
         POS_SEC_ONES: return POS_ALARM;
         default:      return p + 4'd1;
      endcase
   endfunction

   function automatic void nudge_field(logic up, logic tgt);
      case (cursor_pos)
         POS_PM: edit_pm = ~edit_pm;
         POS_HOUR: begin
            if (up) begin
               edit_hour = (edit_hour >= 4'd12) ? 4'd0 : edit_hour + 4'd1;
            end else begin
               edit_hour = (edit_hour == 4'd0) ? 4'd12 : edit_hour - 4'd1;
            end
         end
         POS_MIN_TENS: edit_minute = tens_digit_step(edit_minute, up);
         POS_MIN_ONES: edit_minute = ones_digit_step(edit_minute, up);
         POS_SEC_TENS: edit_second = tens_digit_step(edit_second, up);
         POS_SEC_ONES: edit_second = ones_digit_step(edit_second, up);
         POS_ALARM: begin
            if (tgt == TGT_ALARM) begin
               alarm_off = ~alarm_off;
            end
         end
         default: ;
      endcase
   endfunction

   // key windows are tested in a fixed order, each seeing the latch left by the one before
   function automatic rsp_type predict_edit(req_type t);
      rsp_type    r;
      logic [2:0] fired;
      logic [11:0] s;
      fired = KEY_NONE;
      s = t.ladder_sample;
      case (t.operation)
         OP_SAMPLE: begin
            if (s <= windows.up_max && held_key != KEY_UP) begin
               held_key = KEY_UP;
               fired = KEY_UP;
               nudge_field(1'b1, t.target);
            end
            if (s >= windows.down_min && s <= windows.down_max && held_key != KEY_DOWN) begin
               held_key = KEY_DOWN;
               fired = KEY_DOWN;
               nudge_field(1'b0, t.target);
            end
            if (s >= windows.left_min && s <= windows.left_max && held_key != KEY_LEFT) begin
               held_key = KEY_LEFT;
               fired = KEY_LEFT;
               cursor_pos = cursor_left(cursor_pos);
            end
            if (s >= windows.right_min && s <= windows.right_max
                && held_key != KEY_RIGHT) begin
               held_key = KEY_RIGHT;
               fired = KEY_RIGHT;
               cursor_pos = cursor_right(cursor_pos);
            end
            if (s > windows.right_max) begin
               held_key = KEY_NONE;
            end
         end
         OP_LOAD: begin
            edit_pm = t.load_pm;
            edit_hour = t.load_hour;
            edit_minute = t.load_minute;
            edit_second = t.load_second;
            cursor_pos = POS_PM;
         end
         default: ;
      endcase
      r.key_event = fired;
      r.cursor = cursor_pos;
      r.pm = edit_pm;
      r.hour = edit_hour;
      r.minute = edit_minute;
      r.second = edit_second;
      r.alarm_off = alarm_off;
      r.commit = (t.operation == OP_COMMIT);
      r.commit_target = r.commit ? t.target : 1'b0;
      return r;
   endfunction

   task automatic compare_result(input rsp_type got, input rsp_type want);
      check_field("key_event", int'(got.key_event), int'(want.key_event));
      check_field("cursor", int'(got.cursor), int'(want.cursor));
      check_field("pm", int'(got.pm), int'(want.pm));
      check_field("hour", int'(got.hour), int'(want.hour));
      check_field("minute", int'(got.minute), int'(want.minute));
      check_field("second", int'(got.second), int'(want.second));
      check_field("alarm_off", int'(got.alarm_off), int'(want.alarm_off));
      check_field("commit", int'(got.commit), int'(want.commit));
      check_field("commit_target", int'(got.commit_target), int'(want.commit_target));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         windows = CFG_RESET;
         held_key = KEY_NONE;
         cursor_pos = POS_PM;
         edit_pm = 1'b0;
         edit_hour = 4'd0;
         edit_minute = 6'd0;
         edit_second = 6'd0;
         alarm_off = 1'b1;
         expected_edits.delete();
      end else begin
         // the result side first, so a transaction pushed now is never matched now
         if (!rsp_empty && rsp_pop) begin
            if (expected_edits.size() == 0) begin
               report_mismatch("result with no transaction waiting for it");
            end else begin
               oldest = expected_edits.pop_front();
               compare_result(rsp_data, oldest);
            end
         end
         if (req_push && !req_full) begin
            expected_edits.push_back(predict_edit(req_data));
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_UP_MAX:    windows.up_max = csr_wdata;
               CSR_DOWN_MIN:  windows.down_min = csr_wdata;
               CSR_DOWN_MAX:  windows.down_max = csr_wdata;
               CSR_LEFT_MIN:  windows.left_min = csr_wdata;
               CSR_LEFT_MAX:  windows.left_max = csr_wdata;
               CSR_RIGHT_MIN: windows.right_min = csr_wdata;
               CSR_RIGHT_MAX: windows.right_max = csr_wdata;
               default: ;
            endcase
         end
      end
      pending <= expected_edits.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// top of the keypad time setting editor testbench: clock, reset, stimulus,
// window settings and verdict. depends on kte_pkg, the editor and kte_edit_checker
module testbench;
   import kte_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 200000;
   localparam int PHASE_ITEMS = 180;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int cycles = 0;
   int items_sent = 0;
   int pop_stall = 0;
   logic quiet = 1'b0;
   cfg_type win;

   keypad_time_setting_editor uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   kte_edit_checker edit_check (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("keypad_time_setting_editor verification failed");
         $finish;
      end
   end

   // receiver stalls in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop = 1'b0;
      end else if (quiet) begin
         rsp_pop = 1'b1;
      end else if (pop_stall > 0) begin
         rsp_pop = 1'b0;
         pop_stall--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_pop = 1'b0;
         pop_stall = $urandom_range(0, 5);
      end else begin
         rsp_pop = 1'b1;
      end
   end

   function automatic req_type make_item(logic [1:0] op, logic [11:0] adc, logic tgt,
                                         logic pm, logic [3:0] hr, logic [5:0] mn,
                                         logic [5:0] sc);
      req_type t;
      t.operation = op;
      t.ladder_sample = adc;
      t.target = tgt;
      t.load_pm = pm;
      t.load_hour = hr;
      t.load_minute = mn;
      t.load_second = sc;
      return t;
   endfunction

   // random content in the fields the operation does not use
   function automatic req_type noisy_item(logic [1:0] op, logic [11:0] adc);
      return make_item(op, adc, 1'($urandom), 1'($urandom), 4'($urandom_range(0, 15)),
                       6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
   endfunction

   // entered and left at a falling edge
   task automatic send_item(input req_type t);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_data = t;
      while (req_full) @(negedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic press(input logic [11:0] adc, input logic tgt);
      send_item(make_item(OP_SAMPLE, adc, tgt, 1'b0, 4'd0, 6'd0, 6'd0));
   endtask

   task automatic wait_drained;
      req_push = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [11:0] val);
      csr_wen = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
   endtask

   task automatic write_windows(input cfg_type w);
      write_csr(CSR_UP_MAX, w.up_max);
      write_csr(CSR_DOWN_MIN, w.down_min);
      write_csr(CSR_DOWN_MAX, w.down_max);
      write_csr(CSR_LEFT_MIN, w.left_min);
      write_csr(CSR_LEFT_MAX, w.left_max);
      write_csr(CSR_RIGHT_MIN, w.right_min);
      write_csr(CSR_RIGHT_MAX, w.right_max);
      csr_wen = 1'b0;
      win = w;
   endtask

   function automatic cfg_type phase_windows(int ph);
      cfg_type w;
      case (ph)
         0: w = '{up_max: 12'd100, down_min: 12'd600, down_max: 12'd700,
                  left_min: 12'd1500, left_max: 12'd1800,
                  right_min: 12'd2500, right_max: 12'd2800};
         // heavy overlap, several keys can fire on one sample
         1: w = '{up_max: 12'd0, down_min: 12'd0, down_max: 12'd4095,
                  left_min: 12'd4095, left_max: 12'd4095,
                  right_min: 12'd0, right_max: 12'd4094};
         // no release range, empty down window
         2: w = '{up_max: 12'd4095, down_min: 12'd4095, down_max: 12'd0,
                  left_min: 12'd0, left_max: 12'd0,
                  right_min: 12'd4095, right_max: 12'd4095};
         default: w = CFG_RESET;
      endcase
      return w;
   endfunction

   function automatic logic [11:0] key_sample();
      case ($urandom_range(0, 3))
         0: return 12'($urandom_range(0, win.up_max));
         1: return 12'($urandom_range(win.down_min, win.down_max));
         2: return 12'($urandom_range(win.left_min, win.left_max));
         default: return 12'($urandom_range(win.right_min, win.right_max));
      endcase
   endfunction

   function automatic logic [11:0] release_sample();
      if (win.right_max == 12'hfff) begin
         return 12'($urandom_range(0, 4095));
      end
      return 12'($urandom_range(int'(win.right_max) + 1, 4095));
   endfunction

   task automatic run_random(input int goal);
      int roll;
      goal += items_sent;
      while (items_sent < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            // release then press, sometimes held for another sample
            send_item(noisy_item(OP_SAMPLE, release_sample()));
            send_item(noisy_item(OP_SAMPLE, key_sample()));
            if ($urandom_range(0, 3) == 0) begin
               send_item(noisy_item(OP_SAMPLE, key_sample()));
            end
         end else if (roll < 75) begin
            send_item(noisy_item(OP_LOAD, 12'($urandom_range(0, 4095))));
         end else if (roll < 84) begin
            send_item(noisy_item(OP_COMMIT, 12'($urandom_range(0, 4095))));
         end else if (roll < 87) begin
            send_item(noisy_item(OP_UNUSED, 12'($urandom_range(0, 4095))));
         end else begin
            send_item(noisy_item(OP_SAMPLE, 12'($urandom_range(0, 4095))));
         end
      end
   endtask

   initial begin
      win = CFG_RESET;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // default windows: wraps, latch hold, every field stepped, some both ways
      press(12'd4095, 1'b0);
      press(12'd0, 1'b0);
      press(12'd0, 1'b0);
      press(12'd850, 1'b0);
      press(12'd1930, 1'b1);
      press(12'd850, 1'b1);
      press(12'd2950, 1'b1);
      send_item(make_item(OP_LOAD, 12'd0, 1'b1, 1'b1, 4'd15, 6'd63, 6'd60));
      press(12'd2950, 1'b0);
      press(12'd0, 1'b0);
      press(12'd850, 1'b0);
      press(12'd2950, 1'b0);
      press(12'd0, 1'b0);
      press(12'd850, 1'b0);
      press(12'd2950, 1'b0);
      press(12'd0, 1'b0);
      press(12'd2950, 1'b0);
      press(12'd850, 1'b0);
      press(12'd2950, 1'b0);
      press(12'd0, 1'b0);
      press(12'd2950, 1'b0);
      press(12'd0, 1'b0);
      send_item(make_item(OP_COMMIT, 12'd4095, 1'b1, 1'b1, 4'd15, 6'd63, 6'd63));
      send_item(make_item(OP_UNUSED, 12'd4095, 1'b1, 1'b1, 4'd15, 6'd63, 6'd63));
      send_item(make_item(OP_LOAD, 12'd0, 1'b0, 1'b0, 4'd0, 6'd0, 6'd0));
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         write_windows(phase_windows(ph));
         if (ph == 3) begin
            quiet = 1'b1;
         end
         run_random(PHASE_ITEMS);
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("keypad_time_setting_editor verification clean");
      end else begin
         $display("keypad_time_setting_editor verification failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/kte_pkg.sv
rtl/core/kte_front.sv
rtl/core/kte_back.sv
rtl/core/keypad_time_setting_editor.sv
tb/sv/kte_edit_checker.sv
tb/sv/testbench.sv
